// ----- sv/pcld_pkg.sv -----
// Shared types and codes for the page cache LRU directory.
// Used by pcld_dir and page_cache_lru_directory_unit; depends on nothing.
package pcld_pkg;

  localparam int CapRegW = 5;

  typedef logic [CapRegW-1:0] cap_t;
  typedef logic [3:0]         slot_t;
  typedef logic [31:0]        page_t;
  typedef logic [15:0]        size_t_t;

  localparam cap_t CAP_RESET = 5'd16;

  localparam logic OP_FETCH = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_MISMATCH = 1'b1;

  typedef struct packed {
    logic    op;
    page_t   page_number;
    size_t_t page_size;
  } in_item_t;

  typedef struct packed {
    logic    status;
    logic    hit;
    slot_t   slot;
    logic    evicted;
    page_t   evicted_page;
    size_t_t stored_size;
  } out_item_t;

endpackage

// ----- sv/pcld_dir.sv -----
// Directory store: tags, sizes and recency ranks, with the lookup and update logic.
// Depends on pcld_pkg.
module pcld_dir #(
  parameter int ENTRIES = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  pcld_pkg::in_item_t  item_i,
  input  pcld_pkg::cap_t      capacity_i,
  output pcld_pkg::out_item_t res_o
);

  localparam int AW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW   = $clog2(ENTRIES + 1);
  localparam int CapW = (CW > pcld_pkg::CapRegW) ? CW : pcld_pkg::CapRegW;

  logic                valid_q [ENTRIES];
  logic                valid_d [ENTRIES];
  pcld_pkg::page_t     page_q  [ENTRIES];
  pcld_pkg::size_t_t   size_q  [ENTRIES];
  logic [AW-1:0]       age_q   [ENTRIES];
  logic [AW-1:0]       age_d   [ENTRIES];
  logic [CW-1:0]       occ_q;
  logic [CW-1:0]       occ_d;

  logic                match   [ENTRIES];
  logic                keep    [ENTRIES];
  logic                hit;
  logic [AW-1:0]       hit_idx;
  pcld_pkg::slot_t     hit_slot;
  logic                free_found;
  logic [AW-1:0]       free_idx;
  pcld_pkg::slot_t     free_slot;
  pcld_pkg::size_t_t   hit_size;
  logic [AW-1:0]       hit_age;
  pcld_pkg::page_t     oldest_page;
  logic [CapW-1:0]     eff_cap;
  logic                full;
  logic                is_fetch;
  logic                promote;
  logic                insert;
  logic                size_wr;

  always_comb begin
    logic [CapW-1:0] cap_ext;
    cap_ext = CapW'(capacity_i);
    if (cap_ext == '0) begin
      eff_cap = CapW'(1);
    end else if (cap_ext > CapW'(ENTRIES)) begin
      eff_cap = CapW'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign full     = CapW'(occ_q) >= eff_cap;
  assign is_fetch = item_i.op == pcld_pkg::OP_FETCH;

  always_comb begin
    hit         = 1'b0;
    hit_idx     = '0;
    hit_slot    = '0;
    free_found  = 1'b0;
    free_idx    = '0;
    free_slot   = '0;
    oldest_page = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      match[i] = valid_q[i] && (page_q[i] == item_i.page_number);
      keep[i]  = valid_q[i] && !(full && (CapW'(age_q[i]) >= eff_cap - CapW'(1)));
      if (match[i]) begin
        hit      = 1'b1;
        hit_idx  = AW'(i);
        hit_slot = pcld_pkg::slot_t'(i);
      end
      if (!keep[i]) begin
        free_found = 1'b1;
        free_idx   = AW'(i);
        free_slot  = pcld_pkg::slot_t'(i);
      end
      if (valid_q[i] && (age_q[i] == AW'(occ_q - CW'(1)))) begin
        oldest_page = oldest_page | page_q[i];
      end
    end
  end

  assign hit_size = size_q[hit_idx];
  assign hit_age  = age_q[hit_idx];

  assign promote = en_i && hit && !is_fetch && (hit_size == item_i.page_size);
  assign insert  = en_i && !hit && is_fetch && free_found;
  assign size_wr = en_i && hit && is_fetch;

  always_comb begin
    res_o              = '0;
    res_o.status       = pcld_pkg::STATUS_OK;
    if (hit) begin
      res_o.hit         = 1'b1;
      res_o.slot        = hit_slot;
      if (is_fetch) begin
        res_o.stored_size = item_i.page_size;
      end else begin
        res_o.stored_size = hit_size;
        if (hit_size != item_i.page_size) begin
          res_o.status = pcld_pkg::STATUS_MISMATCH;
        end
      end
    end else if (is_fetch) begin
      res_o.evicted      = full;
      res_o.evicted_page = full ? oldest_page : '0;
      if (free_found) begin
        res_o.slot        = free_slot;
        res_o.stored_size = item_i.page_size;
      end
    end
  end

  always_comb begin
    occ_d = occ_q;
    for (int i = 0; i < ENTRIES; i++) begin
      valid_d[i] = valid_q[i];
      age_d[i]   = age_q[i];
      if (promote && valid_q[i] && (age_q[i] < hit_age)) begin
        age_d[i] = age_q[i] + AW'(1);
      end
      if (insert) begin
        valid_d[i] = keep[i];
        if (keep[i]) begin
          age_d[i] = age_q[i] + AW'(1);
        end
      end
    end
    if (promote) begin
      age_d[hit_idx] = '0;
    end
    if (insert) begin
      valid_d[free_idx] = 1'b1;
      age_d[free_idx]   = '0;
      occ_d             = full ? CW'(eff_cap) : occ_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        valid_q[i] <= 1'b0;
        age_q[i]   <= '0;
      end
    end else begin
      occ_q <= occ_d;
      for (int i = 0; i < ENTRIES; i++) begin
        valid_q[i] <= valid_d[i];
        age_q[i]   <= age_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (insert) begin
      page_q[free_idx] <= item_i.page_number;
      size_q[free_idx] <= item_i.page_size;
    end else if (size_wr) begin
      size_q[hit_idx] <= item_i.page_size;
    end
  end

  logic [ENTRIES-1:0] valid_vec;
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      valid_vec[i] = valid_q[i];
    end
  end

  a_occ_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CW'($countones(valid_vec)) == occ_q)
    else $error("occupancy count differs from number of valid entries");

  a_insert_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    insert |=> valid_q[$past(free_idx)] && (age_q[$past(free_idx)] == '0))
    else $error("inserted entry not valid and most recent");

  a_promote_mru: assert property (@(posedge clk_i) disable iff (!rst_ni)
    promote |=> age_q[$past(hit_idx)] == '0)
    else $error("promoted entry not most recent");

  a_mismatch_on_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && res_o.status == pcld_pkg::STATUS_MISMATCH) |-> (res_o.hit && !is_fetch))
    else $error("size mismatch reported without flush hit");

endmodule

// ----- sv/page_cache_lru_directory_unit.sv -----
// Top level of the page cache LRU directory: capacity register, input and result registers.
// Depends on pcld_pkg and pcld_dir.
//
// Use: items enter on in_valid_i / in_item_i and are taken at an edge where in_stall_o is
// low. Each item yields one result on out_valid_o / out_item_o, taken at an edge where
// out_stall_i is low. Results leave in the order the items came in.
// Flow: an item taken into the input register moves through the lookup and update into the
// result register whenever that register is empty or its result is being taken.
// Throughput: one item per cycle while out_stall_i is low; the tag compare and rank update
// over all entries are combinational between the two registers.
// Stall: while the receiver stalls, the result holds; the next item waits in the input
// register and in_stall_o rises until the result is taken.
// Configuration: cfg_we_i writes cfg_data_i into the capacity register; write only while
// no item is in flight.
// Reset: the directory empties, capacity returns to 16, both channels go idle.
module page_cache_lru_directory_unit #(
  parameter int ENTRIES = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pcld_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pcld_pkg::out_item_t out_item_o,
  input  logic                cfg_we_i,
  input  pcld_pkg::cap_t      cfg_data_i
);

  pcld_pkg::cap_t      capacity_q;
  logic                in_valid_q;
  logic                in_valid_d;
  pcld_pkg::in_item_t  in_item_q;
  logic                out_valid_q;
  logic                out_valid_d;
  pcld_pkg::out_item_t out_item_q;
  pcld_pkg::out_item_t res;
  logic                advance;
  logic                in_take;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  pcld_dir #(
    .ENTRIES (ENTRIES)
  ) u_dir (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (advance),
    .item_i     (in_item_q),
    .capacity_i (capacity_q),
    .res_o      (res)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q  <= pcld_pkg::CAP_RESET;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        capacity_q <= cfg_data_i;
      end
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q <= in_item_i;
    end
    if (advance) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ----- sim/tb_page_cache_lru_directory_unit.sv -----
// Self-checking testbench for page_cache_lru_directory_unit: directed table, then random phases.
// Checks typed rows by table, the rest by an LRU predictor; depends on pcld_pkg and the DUT.
module tb_page_cache_lru_directory_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import pcld_pkg::*;

  localparam int ENTRIES    = 16;
  localparam int HOT_PAGES  = 24;
  localparam int HOLD_LEN   = 48;
  localparam int PHASES     = 8;
  localparam int PHASE_LEN  = 80;

  localparam int PHASE_SEND[PHASES]  = '{0, 51, 0, 10, 0, 51, 0, 10};
  localparam int PHASE_STALL[PHASES] = '{0, 0, 51, 10, 0, 0, 51, 10};
  localparam int PHASE_CAP[PHASES]   = '{16, 1, 5, 31, 8, 0, 16, 2};
  localparam bit PHASE_HOLD[PHASES]  = '{0, 0, 0, 0, 1, 0, 0, 0};

  typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e kind;
    cap_t      cap;
    in_item_t  req;
    bit        typed;
    out_item_t want;
  } step_row_t;

  localparam int DIRECTED_ROWS = 25;
  localparam step_row_t DIRECTED[DIRECTED_ROWS] = '{
    '{ROW_ITEM, 5'd0, '{OP_FLUSH, 32'h0000_0000, 16'h0000}, 1'b1,
      '{STATUS_OK, 1'b0, 4'd0, 1'b0, 32'h0, 16'h0000}},
    '{ROW_ITEM, 5'd0, '{OP_FETCH, 32'h0000_0000, 16'h0000}, 1'b1,
      '{STATUS_OK, 1'b0, 4'd0, 1'b0, 32'h0, 16'h0000}},
    '{ROW_ITEM, 5'd0, '{OP_FETCH, 32'hFFFF_FFFF, 16'hFFFF}, 1'b1,
      '{STATUS_OK, 1'b0, 4'd1, 1'b0, 32'h0, 16'hFFFF}},
    '{ROW_ITEM, 5'd0, '{OP_FLUSH, 32'hFFFF_FFFF, 16'hFFFF}, 1'b1,
      '{STATUS_OK, 1'b1, 4'd1, 1'b0, 32'h0, 16'hFFFF}},
    '{ROW_ITEM, 5'd0, '{OP_FLUSH, 32'hFFFF_FFFF, 16'h0000}, 1'b1,
      '{STATUS_MISMATCH, 1'b1, 4'd1, 1'b0, 32'h0, 16'hFFFF}},
    '{ROW_ITEM, 5'd0, '{OP_FETCH, 32'h0000_0000, 16'h1234}, 1'b1,
      '{STATUS_OK, 1'b1, 4'd0, 1'b0, 32'h0, 16'h1234}},
    '{ROW_ITEM, 5'd0, '{OP_FETCH, 32'h8000_0000, 16'h8000}, 1'b0, '0},
    '{ROW_ITEM, 5'd0, '{OP_FETCH, 32'h5555_5555, 16'h5555}, 1'b0, '0},
    '{ROW_ITEM, 5'd0, '{OP_FETCH, 32'hAAAA_AAAA, 16'hAAAA}, 1'b0, '0},
    '{ROW_ITEM, 5'd0, '{OP_FLUSH, 32'h0000_0000, 16'h1234}, 1'b0, '0},
    '{ROW_CFG,  5'd2, '0, 1'b0, '0},
    '{ROW_ITEM, 5'd0, '{OP_FETCH, 32'h1234_5678, 16'h0007}, 1'b0, '0},
    '{ROW_ITEM, 5'd0, '{OP_FETCH, 32'h0000_0001, 16'h0001}, 1'b0, '0},
    '{ROW_CFG,  5'd0, '0, 1'b0, '0},
    '{ROW_ITEM, 5'd0, '{OP_FETCH, 32'h0000_0002, 16'h0002}, 1'b0, '0},
    '{ROW_ITEM, 5'd0, '{OP_FETCH, 32'h0000_0003, 16'h0003}, 1'b0, '0},
    '{ROW_ITEM, 5'd0, '{OP_FLUSH, 32'h0000_0003, 16'h0003}, 1'b0, '0},
    '{ROW_CFG,  5'd3, '0, 1'b0, '0},
    '{ROW_ITEM, 5'd0, '{OP_FETCH, 32'h0000_0010, 16'h0010}, 1'b0, '0},
    '{ROW_ITEM, 5'd0, '{OP_FETCH, 32'h0000_0011, 16'h0011}, 1'b0, '0},
    '{ROW_ITEM, 5'd0, '{OP_FETCH, 32'h0000_0012, 16'h0012}, 1'b0, '0},
    '{ROW_ITEM, 5'd0, '{OP_FLUSH, 32'h0000_0011, 16'h0011}, 1'b0, '0},
    '{ROW_ITEM, 5'd0, '{OP_FETCH, 32'h0000_0013, 16'h0013}, 1'b0, '0},
    '{ROW_CFG,  5'd31, '0, 1'b0, '0},
    '{ROW_ITEM, 5'd0, '{OP_FETCH, 32'h0000_0014, 16'h0014}, 1'b0, '0}
  };

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;
  logic      cfg_we;
  cap_t      cfg_data;

  bit        dir_valid [ENTRIES];
  page_t     dir_page  [ENTRIES];
  size_t_t   dir_size  [ENTRIES];
  int        dir_rank  [ENTRIES];
  int        dir_count = 0;
  cap_t      cap_reg   = CAP_RESET;

  out_item_t pending_results [$];
  page_t     hot_pages [HOT_PAGES];

  int send_idle_pct = 0;
  int stall_pct     = 0;
  bit hold_req      = 1'b0;
  int errors        = 0;
  int items_sent    = 0;
  int results_seen  = 0;
  int hit_count     = 0;
  int evict_count   = 0;
  int size_errs     = 0;
  int cap_writes    = 0;

  page_cache_lru_directory_unit #(.ENTRIES(ENTRIES)) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1_000_000;
    $display("tb_page_cache_lru_directory_unit: done, errors");
    $finish;
  end

  task automatic note_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    errors++;
  endtask

  function automatic out_item_t lru_lookup(input in_item_t req);
    out_item_t res;
    int found;
    int free_slot;
    int eff_cap;
    int oldest;
    res = '0;
    found = -1;
    free_slot = -1;
    eff_cap = (cap_reg == 0) ? 1 : ((cap_reg > ENTRIES) ? ENTRIES : int'(cap_reg));
    for (int i = 0; i < ENTRIES; i++) begin
      if (found < 0 && dir_valid[i] && dir_page[i] == req.page_number) found = i;
    end
    if (found >= 0) begin
      res.hit  = 1'b1;
      res.slot = slot_t'(found);
      if (req.op == OP_FETCH) begin
        dir_size[found] = req.page_size;
        res.stored_size = req.page_size;
      end else if (dir_size[found] != req.page_size) begin
        res.status      = STATUS_MISMATCH;
        res.stored_size = dir_size[found];
      end else begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (dir_valid[i] && dir_rank[i] < dir_rank[found]) dir_rank[i]++;
        end
        dir_rank[found] = 0;
        res.stored_size = dir_size[found];
      end
    end else if (req.op == OP_FETCH) begin
      if (dir_count >= eff_cap) begin
        oldest = -1;
        for (int i = 0; i < ENTRIES; i++) begin
          if (dir_valid[i] && dir_rank[i] > oldest) begin
            oldest           = dir_rank[i];
            res.evicted_page = dir_page[i];
          end
        end
        res.evicted = 1'b1;
        for (int i = 0; i < ENTRIES; i++) begin
          if (dir_valid[i] && dir_rank[i] >= eff_cap - 1) begin
            dir_valid[i] = 1'b0;
            dir_count--;
          end
        end
      end
      for (int i = 0; i < ENTRIES; i++) begin
        if (free_slot < 0 && !dir_valid[i]) free_slot = i;
      end
      for (int i = 0; i < ENTRIES; i++) begin
        if (dir_valid[i]) dir_rank[i]++;
      end
      dir_valid[free_slot] = 1'b1;
      dir_page[free_slot]  = req.page_number;
      dir_size[free_slot]  = req.page_size;
      dir_rank[free_slot]  = 0;
      dir_count++;
      res.slot        = slot_t'(free_slot);
      res.stored_size = req.page_size;
    end
    return res;
  endfunction

  function automatic in_item_t pick_request();
    in_item_t req;
    int sel;
    req.op = 1'($urandom_range(1));
    if ($urandom_range(99) < 75) req.page_number = hot_pages[$urandom_range(HOT_PAGES - 1)];
    else req.page_number = $urandom;
    sel = $urandom_range(7);
    if (sel == 0) req.page_size = 16'h0000;
    else if (sel == 1) req.page_size = 16'hFFFF;
    else req.page_size = 16'($urandom);
    if (req.op == OP_FLUSH && $urandom_range(99) < 70) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (dir_valid[i] && dir_page[i] == req.page_number) req.page_size = dir_size[i];
      end
    end
    return req;
  endfunction

  task automatic send_item(input in_item_t req, input bit typed, input out_item_t want);
    out_item_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= req;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    predicted = lru_lookup(req);
    pending_results.push_back(typed ? want : predicted);
    items_sent++;
    hit_count   += predicted.hit;
    evict_count += predicted.evicted;
    size_errs   += (predicted.status == STATUS_MISMATCH);
    @(negedge clk_i);
  endtask

  task automatic settle_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_capacity(input cap_t value);
    settle_idle();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(negedge clk_i);
    cfg_we   <= 1'b0;
    cap_reg = value;
    cap_writes++;
  endtask

  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_left = HOLD_LEN;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    out_item_t got;
    out_item_t want;
    if (rst_ni && out_valid && !out_stall) begin
      got = out_item;
      results_seen++;
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("result %h with nothing pending", got));
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status)
          note_mismatch($sformatf("status got %0h want %0h", got.status, want.status));
        if (got.hit !== want.hit)
          note_mismatch($sformatf("hit got %0h want %0h", got.hit, want.hit));
        if (got.slot !== want.slot)
          note_mismatch($sformatf("slot got %0d want %0d", got.slot, want.slot));
        if (got.evicted !== want.evicted)
          note_mismatch($sformatf("evicted got %0h want %0h", got.evicted, want.evicted));
        if (got.evicted_page !== want.evicted_page)
          note_mismatch($sformatf("evicted_page got %h want %h",
                                  got.evicted_page, want.evicted_page));
        if (got.stored_size !== want.stored_size)
          note_mismatch($sformatf("stored_size got %h want %h",
                                  got.stored_size, want.stored_size));
      end
    end
  end

  initial begin : stimulus
    rst_ni   = 1'b0;
    in_valid = 1'b0;
    in_item  = '0;
    cfg_we   = 1'b0;
    cfg_data = '0;
    hot_pages[0] = 32'h0000_0000;
    hot_pages[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < HOT_PAGES; i++) hot_pages[i] = $urandom;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      if (DIRECTED[r].kind == ROW_CFG) write_capacity(DIRECTED[r].cap);
      else send_item(DIRECTED[r].req, DIRECTED[r].typed, DIRECTED[r].want);
    end

    for (int p = 0; p < PHASES; p++) begin
      write_capacity(cap_t'(PHASE_CAP[p]));
      send_idle_pct = PHASE_SEND[p];
      stall_pct     = PHASE_STALL[p];
      for (int n = 0; n < PHASE_LEN; n++) begin
        if (PHASE_HOLD[p] && (n == 0 || n == PHASE_LEN / 2)) hold_req = 1'b1;
        send_item(pick_request(), 1'b0, '0);
      end
    end

    send_idle_pct = 0;
    stall_pct     = 0;
    settle_idle();
    repeat (6) @(negedge clk_i);

    $display("run covered %0d items, %0d results, %0d capacity writes",
             items_sent, results_seen, cap_writes);
    $display("directory saw %0d hits, %0d evicting fetches, %0d flush size mismatches",
             hit_count, evict_count, size_errs);
    if (errors == 0) begin
      $display("tb_page_cache_lru_directory_unit: done, clean");
    end else begin
      $display("tb_page_cache_lru_directory_unit: done, errors");
    end
    $finish;
  end

endmodule
